@@ design/min_heap_priority_queue_core_defines.svh @@
// Assertion macros used by the checker.
`ifndef MIN_HEAP_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define MIN_HEAP_PRIORITY_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define MHPQ_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define MHPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/mhpq_pkg.sv @@
`timescale 1ns / 1ps
package mhpq_pkg;

   localparam int DEPTH = 256;
   localparam int IW    = $clog2(DEPTH);
   localparam int CW    = IW + 1;
   localparam int SW    = 4;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_UNDERFLOW = 2'd1;
   localparam logic [1:0] ST_OVERFLOW  = 2'd2;

   typedef struct packed {
      logic [15:0] data;
      logic [31:0] prio;
   } entry_type;

   // datapath operations
   localparam logic [3:0] OP_IDLE      = 4'd0;
   localparam logic [3:0] OP_NOP       = 4'd1;
   localparam logic [3:0] OP_INS_INIT  = 4'd2;
   localparam logic [3:0] OP_RD_PARENT = 4'd3;
   localparam logic [3:0] OP_SU_MOVE   = 4'd4;
   localparam logic [3:0] OP_SU_PLACE  = 4'd5;
   localparam logic [3:0] OP_DONE      = 4'd6;
   localparam logic [3:0] OP_EXT_INIT  = 4'd7;
   localparam logic [3:0] OP_EXT_ROOT  = 4'd8;
   localparam logic [3:0] OP_RD_C1     = 4'd9;
   localparam logic [3:0] OP_RD_C2     = 4'd10;
   localparam logic [3:0] OP_WK_MOVE   = 4'd11;
   localparam logic [3:0] OP_RI_INIT   = 4'd12;
   localparam logic [3:0] OP_RD_CUR    = 4'd13;
   localparam logic [3:0] OP_RI_LOAD   = 4'd14;
   localparam logic [3:0] OP_EXT_END   = 4'd15;

   // jump conditions
   localparam logic [3:0] C_NEVER     = 4'd0;
   localparam logic [3:0] C_ALWAYS    = 4'd1;
   localparam logic [3:0] C_NOSTART   = 4'd2;
   localparam logic [3:0] C_EXTRACT   = 4'd3;
   localparam logic [3:0] C_FULL      = 4'd4;
   localparam logic [3:0] C_S_ZERO    = 4'd5;
   localparam logic [3:0] C_LESS      = 4'd6;
   localparam logic [3:0] C_EMPTY     = 4'd7;
   localparam logic [3:0] C_ONE       = 4'd8;
   localparam logic [3:0] C_HAS_CHILD = 4'd9;
   localparam logic [3:0] C_CUR_DONE  = 4'd10;

   // program steps
   localparam logic [SW-1:0] S_IDLE     = 4'd0;
   localparam logic [SW-1:0] S_DISPATCH = 4'd1;
   localparam logic [SW-1:0] S_INS      = 4'd2;
   localparam logic [SW-1:0] S_SU_TOP   = 4'd3;
   localparam logic [SW-1:0] S_SU_CMP   = 4'd4;
   localparam logic [SW-1:0] S_SU_PLACE = 4'd5;
   localparam logic [SW-1:0] S_DONE     = 4'd6;
   localparam logic [SW-1:0] S_EXT      = 4'd7;
   localparam logic [SW-1:0] S_EXT_ROOT = 4'd8;
   localparam logic [SW-1:0] S_WK_C1    = 4'd9;
   localparam logic [SW-1:0] S_WK_C2    = 4'd10;
   localparam logic [SW-1:0] S_WK_MOVE  = 4'd11;
   localparam logic [SW-1:0] S_WK_TEST  = 4'd12;
   localparam logic [SW-1:0] S_RI_TEST  = 4'd13;
   localparam logic [SW-1:0] S_RI_LOAD  = 4'd14;
   localparam logic [SW-1:0] S_EXT_END  = 4'd15;

   typedef struct packed {
      logic [3:0]    op;
      logic [3:0]    cond;
      logic [SW-1:0] target;
   } ucode_type;

   function automatic ucode_type ucode_rom(input logic [SW-1:0] step);
      ucode_type uw;
      unique case (step)
         S_IDLE:     uw = '{OP_IDLE,      C_NOSTART,   S_IDLE};
         S_DISPATCH: uw = '{OP_NOP,       C_EXTRACT,   S_EXT};
         S_INS:      uw = '{OP_INS_INIT,  C_FULL,      S_DONE};
         S_SU_TOP:   uw = '{OP_RD_PARENT, C_S_ZERO,    S_SU_PLACE};
         S_SU_CMP:   uw = '{OP_SU_MOVE,   C_LESS,      S_SU_TOP};
         S_SU_PLACE: uw = '{OP_SU_PLACE,  C_EXTRACT,   S_RI_TEST};
         S_DONE:     uw = '{OP_DONE,      C_ALWAYS,    S_IDLE};
         S_EXT:      uw = '{OP_EXT_INIT,  C_EMPTY,     S_DONE};
         S_EXT_ROOT: uw = '{OP_EXT_ROOT,  C_ONE,       S_DONE};
         S_WK_C1:    uw = '{OP_RD_C1,     C_NEVER,     S_IDLE};
         S_WK_C2:    uw = '{OP_RD_C2,     C_NEVER,     S_IDLE};
         S_WK_MOVE:  uw = '{OP_WK_MOVE,   C_NEVER,     S_IDLE};
         S_WK_TEST:  uw = '{OP_RI_INIT,   C_HAS_CHILD, S_WK_C1};
         S_RI_TEST:  uw = '{OP_RD_CUR,    C_CUR_DONE,  S_EXT_END};
         S_RI_LOAD:  uw = '{OP_RI_LOAD,   C_ALWAYS,    S_SU_TOP};
         S_EXT_END:  uw = '{OP_EXT_END,   C_ALWAYS,    S_DONE};
      endcase
      return uw;
   endfunction

endpackage

@@ design/mhpq_ram.sv @@
`timescale 1ns / 1ps
module mhpq_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

@@ design/min_heap_priority_queue_core.sv @@
`timescale 1ns / 1ps
// channel   | handshake            | payload
// ----------+----------------------+-------------------------------------------
// request   | start / busy         | req_mode, req_item_data, req_item_priority
// response  | rsp_valid (1 cycle)  | rsp_out_data, rsp_status, rsp_occupancy
//
// A 16-step microprogram drives one single-port-read heap RAM; a step that
// uses read data follows the step that issued the address. Insert sifts the
// new entry up from the next free slot, one parent read per level; a full
// queue gets an overflow response. Extract takes the root, pulls the smaller
// child up level by level to a leaf, then moves each entry stored after the
// final hole back one slot and sifts it up; an empty queue gets underflow.
// Reset clears the step counter, entry count and strobe; the heap RAM needs
// no clearing pass. The response is a one-cycle strobe with no back-pressure;
// busy drops in the cycle the strobe shows, so the next transfer may start there.
module min_heap_priority_queue_core
   import mhpq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  logic          req_mode,
   input  logic [15:0]   req_item_data,
   input  logic [31:0]   req_item_priority,
   output logic          rsp_valid,
   output logic [15:0]   rsp_out_data,
   output logic [1:0]    rsp_status,
   output logic [CW-1:0] rsp_occupancy
);

   logic [SW-1:0] step_ff, step_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [IW-1:0] s_ff, s_in;
   logic [IW-1:0] p_ff, p_in;
   logic [CW-1:0] cur_ff, cur_in;
   logic          mode_ff, mode_in;
   entry_type     hold_ff, hold_in;
   entry_type     best_ff, best_in;
   logic [15:0]   res_ff, res_in;
   logic [1:0]    status_ff, status_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   rsp_data_ff, rsp_data_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [CW-1:0] rsp_occ_ff, rsp_occ_in;

   ucode_type     uw;
   logic          jump;
   logic          we;
   logic [IW-1:0] waddr, raddr;
   entry_type     wdata, rd_entry;
   logic [IW-1:0] parent;
   logic [CW-1:0] c1;
   logic [CW:0]   c2;
   logic          has_child, c2_ok, less, pick_c2;

   mhpq_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rd_entry)
   );

   assign uw        = ucode_rom(step_ff);
   assign busy      = (step_ff != S_IDLE);
   assign parent    = (s_ff - IW'(1)) >> 1;
   assign c1        = {p_ff, 1'b1};
   assign c2        = {1'b0, p_ff, 1'b0} + (CW + 1)'(2);
   assign has_child = (c1 < cnt_ff);
   assign c2_ok     = (c2 < {1'b0, cnt_ff});
   assign less      = (hold_ff.prio < rd_entry.prio);
   // on a tie the right child moves up
   assign pick_c2   = c2_ok && !(best_ff.prio < rd_entry.prio);

   always_comb begin
      unique case (uw.cond)
         C_NEVER:     jump = 1'b0;
         C_ALWAYS:    jump = 1'b1;
         C_NOSTART:   jump = !start;
         C_EXTRACT:   jump = mode_ff;
         C_FULL:      jump = (cnt_ff == CW'(DEPTH));
         C_S_ZERO:    jump = (s_ff == '0);
         C_LESS:      jump = less;
         C_EMPTY:     jump = (cnt_ff == '0);
         C_ONE:       jump = (cnt_ff == CW'(1));
         C_HAS_CHILD: jump = has_child;
         C_CUR_DONE:  jump = (cur_ff >= cnt_ff);
         default:     jump = 1'b0;
      endcase
      step_in = jump ? uw.target : step_ff + SW'(1);
   end

   always_comb begin
      cnt_in        = cnt_ff;
      s_in          = s_ff;
      p_in          = p_ff;
      cur_in        = cur_ff;
      mode_in       = mode_ff;
      hold_in       = hold_ff;
      best_in       = best_ff;
      res_in        = res_ff;
      status_in     = status_ff;
      rsp_valid_in  = 1'b0;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_occ_in    = rsp_occ_ff;
      we            = 1'b0;
      waddr         = s_ff;
      wdata         = hold_ff;
      raddr         = '0;
      unique case (uw.op)
         OP_IDLE: begin
            if (start) begin
               mode_in   = req_mode;
               hold_in   = '{data: req_item_data, prio: req_item_priority};
               res_in    = '0;
               status_in = ST_OK;
            end
         end
         OP_NOP: begin
         end
         OP_INS_INIT: begin
            if (cnt_ff == CW'(DEPTH)) begin
               status_in = ST_OVERFLOW;
            end else begin
               s_in   = cnt_ff[IW-1:0];
               cnt_in = cnt_ff + CW'(1);
            end
         end
         OP_RD_PARENT: begin
            raddr = parent;
         end
         OP_SU_MOVE: begin
            // pull the parent down into the hole and climb
            if (less) begin
               we    = 1'b1;
               waddr = s_ff;
               wdata = rd_entry;
               s_in  = parent;
            end
         end
         OP_SU_PLACE: begin
            we    = 1'b1;
            waddr = s_ff;
            wdata = hold_ff;
         end
         OP_DONE: begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = res_ff;
            rsp_status_in = status_ff;
            rsp_occ_in    = cnt_ff;
         end
         OP_EXT_INIT: begin
            if (cnt_ff == '0) begin
               status_in = ST_UNDERFLOW;
            end
            p_in  = '0;
            raddr = '0;
         end
         OP_EXT_ROOT: begin
            res_in = rd_entry.data;
            if (cnt_ff == CW'(1)) begin
               cnt_in = '0;
            end
         end
         OP_RD_C1: begin
            raddr = c1[IW-1:0];
         end
         OP_RD_C2: begin
            best_in = rd_entry;
            raddr   = c2[IW-1:0];
         end
         OP_WK_MOVE: begin
            we    = 1'b1;
            waddr = p_ff;
            wdata = pick_c2 ? rd_entry : best_ff;
            p_in  = pick_c2 ? c2[IW-1:0] : c1[IW-1:0];
         end
         OP_RI_INIT: begin
            cur_in = {1'b0, p_ff} + CW'(1);
         end
         OP_RD_CUR: begin
            raddr = cur_ff[IW-1:0];
         end
         OP_RI_LOAD: begin
            // shift the entry back one slot, then sift it up
            hold_in = rd_entry;
            s_in    = IW'(cur_ff - CW'(1));
            cur_in  = cur_ff + CW'(1);
         end
         OP_EXT_END: begin
            cnt_in = cnt_ff - CW'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff          <= s_in;
      p_ff          <= p_in;
      cur_ff        <= cur_in;
      mode_ff       <= mode_in;
      hold_ff       <= hold_in;
      best_ff       <= best_in;
      res_ff        <= res_in;
      status_ff     <= status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_data  = rsp_data_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_occupancy = rsp_occ_ff;

endmodule

@@ design/mhpq_checker.sv @@
`timescale 1ns / 1ps
`include "min_heap_priority_queue_core_defines.svh"
module mhpq_checker
   import mhpq_pkg::*;
(
   input logic          clock,
   input logic          reset,
   input logic          start,
   input logic          busy,
   input logic          rsp_valid,
   input logic [15:0]   rsp_out_data,
   input logic [1:0]    rsp_status,
   input logic [CW-1:0] rsp_occupancy
);

   `MHPQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transfer did not raise busy")
   `MHPQ_ASSERT_IMPL(a_rsp_idle, rsp_valid, !busy, "response shown while busy")
   `MHPQ_ASSERT_NEXT(a_rsp_pulse, rsp_valid, !rsp_valid, "response strobe longer than one cycle")
   `MHPQ_ASSERT_IMPL(a_err_zero, rsp_valid && rsp_status != ST_OK, rsp_out_data == '0, "error response carries data")
   `MHPQ_ASSERT_IMPL(a_unf_empty, rsp_valid && rsp_status == ST_UNDERFLOW, rsp_occupancy == '0, "underflow with entries held")

endmodule

bind min_heap_priority_queue_core mhpq_checker u_mhpq_checker (.*);

@@ dv/min_heap_priority_queue_core_tb.sv @@
`timescale 1ns / 1ps
module min_heap_priority_queue_core_tb;
   import mhpq_pkg::*;

   localparam logic MODE_INSERT  = 1'b0;
   localparam logic MODE_EXTRACT = 1'b1;
   localparam int   STALL_LIMIT  = 50000;

   typedef struct {
      logic [15:0]   data;
      logic [1:0]    status;
      logic [CW-1:0] occupancy;
   } heap_response_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          start = 1'b0;
   logic          busy;
   logic          req_mode = MODE_INSERT;
   logic [15:0]   req_item_data = '0;
   logic [31:0]   req_item_priority = '0;
   logic          rsp_valid;
   logic [15:0]   rsp_out_data;
   logic [1:0]    rsp_status;
   logic [CW-1:0] rsp_occupancy;

   // shadow heap, only slots below heap_count are ever read
   entry_type         heap_model [DEPTH];
   int unsigned       heap_count = 0;
   heap_response_type expected_responses [$];

   int sender_idle_pct = 0;
   int error_count     = 0;
   int insert_count    = 0;
   int extract_count   = 0;
   int overflow_count  = 0;
   int underflow_count = 0;
   int checked_count   = 0;
   int peak_occupancy  = 0;
   int stall_cycles    = 0;

   min_heap_priority_queue_core dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_item_data     (req_item_data),
      .req_item_priority (req_item_priority),
      .rsp_valid         (rsp_valid),
      .rsp_out_data      (rsp_out_data),
      .rsp_status        (rsp_status),
      .rsp_occupancy     (rsp_occupancy)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void heap_sift_up(int unsigned pos, entry_type ent);
      int unsigned slot;
      int unsigned parent;
      slot = pos;
      while (slot > 0) begin
         parent = (slot - 1) / 2;
         if (!(ent.prio < heap_model[parent].prio))
            break;
         heap_model[slot] = heap_model[parent];
         slot = parent;
      end
      heap_model[slot] = ent;
   endfunction

   function automatic heap_response_type predict_heap_op(logic mode, entry_type ent);
      heap_response_type rsp;
      int unsigned       n;
      int unsigned       hole;
      int unsigned       left;
      int unsigned       right;
      int unsigned       pick;
      entry_type         moved;
      n = heap_count;
      rsp.data   = '0;
      rsp.status = ST_OK;
      if (mode == MODE_INSERT) begin
         insert_count++;
         if (n >= DEPTH) begin
            rsp.status = ST_OVERFLOW;
            overflow_count++;
         end else begin
            heap_count = n + 1;
            heap_sift_up(n, ent);
         end
      end else begin
         extract_count++;
         if (n == 0) begin
            rsp.status = ST_UNDERFLOW;
            underflow_count++;
         end else begin
            rsp.data = heap_model[0].data;
            if (n > 1) begin
               // pull the smaller child up to a leaf; a tie moves the right child
               hole = 0;
               do begin
                  left  = 2 * hole + 1;
                  right = 2 * hole + 2;
                  if (right > n - 1 || heap_model[left].prio < heap_model[right].prio)
                     pick = left;
                  else
                     pick = right;
                  heap_model[hole] = heap_model[pick];
                  hole = pick;
               end while (2 * hole + 1 <= n - 1);
               // shift later entries back one slot, in index order
               for (int unsigned cur = hole + 1; cur < n; cur++) begin
                  moved = heap_model[cur];
                  heap_sift_up(cur - 1, moved);
               end
            end
            heap_count = n - 1;
         end
      end
      rsp.occupancy = heap_count[CW-1:0];
      if (heap_count > peak_occupancy)
         peak_occupancy = heap_count;
      return rsp;
   endfunction

   function automatic logic [31:0] pick_priority();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($urandom_range(7));
         2: return ($urandom_range(1)) ? 32'hFFFF_FFFF : 32'h0000_0000;
         default: return {$urandom_range(3) == 0 ? 8'hFF : 8'h00, 24'($urandom_range(4095))};
      endcase
   endfunction

   // Present one request at the falling edge and hold it until the transfer.
   task automatic send_request(logic mode, logic [15:0] data, logic [31:0] prio);
      entry_type ent;
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start             <= 1'b1;
      req_mode          <= mode;
      req_item_data     <= data;
      req_item_priority <= prio;
      do @(posedge clock); while (busy);
      ent.data = data;
      ent.prio = prio;
      expected_responses.push_back(predict_heap_op(mode, ent));
      @(negedge clock);
   endtask

   task automatic send_random(int insert_pct);
      send_request(($urandom_range(99) < insert_pct) ? MODE_INSERT : MODE_EXTRACT,
                   16'($urandom_range(16'hFFFF)), pick_priority());
   endtask

   task automatic test_empty_extract();
      send_request(MODE_EXTRACT, 16'hA5A5, 32'h0000_0001);
      send_request(MODE_EXTRACT, 16'hFFFF, 32'hFFFF_FFFF);
   endtask

   task automatic test_field_extremes();
      send_request(MODE_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
      send_request(MODE_INSERT, 16'h0000, 32'h0000_0000);
      send_request(MODE_INSERT, 16'h8001, 32'h8000_0000);
      send_request(MODE_INSERT, 16'h7FFE, 32'h7FFF_FFFF);
      repeat (4) send_request(MODE_EXTRACT, 16'h5A5A, 32'h1234_5678);
   endtask

   // Equal keys exercise both the no-swap insert and the right-child tie rule.
   task automatic test_equal_priorities();
      for (int i = 1; i <= 6; i++)
         send_request(MODE_INSERT, 16'(i), 32'd5);
      send_request(MODE_INSERT, 16'h0007, 32'd3);
      repeat (7) send_request(MODE_EXTRACT, 16'h0000, 32'd0);
   endtask

   task automatic test_mixed_traffic(int num_items, int insert_pct);
      repeat (num_items) send_random(insert_pct);
   endtask

   // Drive the queue to full and past it, then drain it past empty.
   task automatic test_fill_and_drain();
      int goal;
      goal = overflow_count + 6;
      while (overflow_count < goal)
         send_random(85);
      goal = underflow_count + 4;
      while (underflow_count < goal)
         send_random(15);
   endtask

   always @(posedge clock) begin
      heap_response_type want;
      if (!reset && rsp_valid) begin
         if (expected_responses.size() == 0) begin
            $display("%0t: unexpected response: data %h status %0d occupancy %0d",
                     $time, rsp_out_data, rsp_status, rsp_occupancy);
            error_count++;
         end else begin
            want = expected_responses.pop_front();
            checked_count++;
            if (rsp_out_data !== want.data) begin
               $display("%0t: out_data mismatch: expected %h, actual %h",
                        $time, want.data, rsp_out_data);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status mismatch: expected %0d, actual %0d",
                        $time, want.status, rsp_status);
               error_count++;
            end
            if (rsp_occupancy !== want.occupancy) begin
               $display("%0t: occupancy mismatch: expected %0d, actual %0d",
                        $time, want.occupancy, rsp_occupancy);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      sender_idle_pct = 0;
      test_empty_extract();
      test_field_extremes();
      test_equal_priorities();
      test_mixed_traffic(250, 55);
      sender_idle_pct = 56;
      test_fill_and_drain();
      sender_idle_pct = 15;
      test_mixed_traffic(270, 55);
      start <= 1'b0;

      while (expected_responses.size() != 0)
         @(posedge clock);
      repeat (50) @(posedge clock);

      $display("covered %0d inserts (%0d dropped when full) and %0d extracts (%0d on empty)",
               insert_count, overflow_count, extract_count, underflow_count);
      $display("peak occupancy %0d of %0d, %0d responses checked, %0d mismatches",
               peak_occupancy, DEPTH, checked_count, error_count);
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+design
design/mhpq_pkg.sv
design/mhpq_ram.sv
design/min_heap_priority_queue_core.sv
design/mhpq_checker.sv
dv/min_heap_priority_queue_core_tb.sv
